[rtl/tbc_pkg.sv]
// shared types and constants for the text/binary classifier
package tbc_pkg;

    localparam int unsigned BUFFER_BYTES_DEF = 1024;
    localparam int unsigned MAX_BYTES_W      = 11;
    localparam logic [MAX_BYTES_W-1:0] MAX_BYTES_RESET = 11'd1024;

    localparam logic [15:0] BOM_LE_HEAD   = 16'hFEFF;
    localparam logic [15:0] BOM_BE_HEAD   = 16'hFFFE;
    localparam logic [23:0] BOM_UTF8_HEAD = 24'hBFBBEF;

    localparam logic [15:0] SURR_MASK     = 16'hF800;
    localparam logic [15:0] SURR_BASE     = 16'hD800;
    localparam logic [15:0] LOW_SURR_MASK = 16'hFC00;
    localparam logic [15:0] LOW_SURR_BASE = 16'hDC00;

    typedef enum logic [2:0] {
        REASON_EMPTY     = 3'd0,
        REASON_PLAIN     = 3'd1,
        REASON_UTF8_BOM  = 3'd2,
        REASON_UTF16_OK  = 3'd3,
        REASON_NULL_BYTE = 3'd4,
        REASON_UTF16_BAD = 3'd5
    } t_reason;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last_item;
    } t_item;

    typedef struct packed {
        logic    bin_flag;
        t_reason reason;
    } t_result;

endpackage

[rtl/text_binary_classifier.sv]
// top level: file head text/binary classifier, one byte request per cycle unless stalled
// path: a last request is registered at the input, then its verdict in the output buffer
// rate: one request per cycle unless stalled; the state update is a single registered pass
// output: two-entry buffer, so requests keep flowing while a verdict waits to be taken
// reset: synchronous active-low i_rst_n clears stream state and sets max bytes to 1024
module text_binary_classifier #(
    parameter int unsigned BUFFER_BYTES = tbc_pkg::BUFFER_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tbc_pkg::MAX_BYTES_W-1:0] i_cfg_wdata,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_byte_present,
    input  logic                            i_last_item,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_is_binary_verdict,
    output logic [2:0]                      o_reason_code
);
    import tbc_pkg::*;

    t_item   in_item;
    t_item   reg_item;
    logic    reg_valid;
    logic    core_take;
    logic    out_ready;
    logic    res_valid;
    t_result core_res;
    t_result out_res;

    assign in_item = '{data_byte: i_data_byte, byte_present: i_byte_present,
                       last_item: i_last_item};

    tbc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .o_valid (reg_valid),
        .o_item  (reg_item),
        .i_take  (core_take)
    );

    tbc_core #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (reg_valid),
        .i_item      (reg_item),
        .i_out_ready (out_ready),
        .o_take      (core_take),
        .o_res_valid (res_valid),
        .o_res       (core_res)
    );

    tbc_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_res   (core_res),
        .o_ready (out_ready),
        .o_valid (o_valid),
        .o_res   (out_res),
        .i_ready (i_ready)
    );

    assign o_is_binary_verdict = out_res.bin_flag;
    assign o_reason_code       = 3'(out_res.reason);

endmodule

[rtl/tbc_in_reg.sv]
// input register stage for incoming byte requests
module tbc_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  tbc_pkg::t_item i_item,
    output logic          o_valid,
    output tbc_pkg::t_item o_item,
    input  logic          i_take
);
    import tbc_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

[rtl/tbc_core.sv]
// running stream flags, utf-16 surrogate check and verdict logic
module tbc_core #(
    parameter int unsigned BUFFER_BYTES = tbc_pkg::BUFFER_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tbc_pkg::MAX_BYTES_W-1:0]  i_cfg_wdata,
    input  logic                             i_valid,
    input  tbc_pkg::t_item                   i_item,
    input  logic                             i_out_ready,
    output logic                             o_take,
    output logic                             o_res_valid,
    output tbc_pkg::t_result                 o_res
);
    import tbc_pkg::*;

    localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);
    localparam int unsigned LW = (CW > MAX_BYTES_W) ? CW : MAX_BYTES_W;

    logic [MAX_BYTES_W-1:0] r_max_bytes;
    logic [CW-1:0]          r_count, n_count;
    logic [23:0]            r_head, n_head;
    logic                   r_zero, n_zero;
    logic [7:0]             r_held, n_held;
    logic                   r_await, n_await;
    logic                   r_fault, n_fault;

    logic [LW-1:0] limit;
    logic          take_byte;
    logic [15:0]   unit;
    logic          bom;
    logic          utf16_ok;
    t_result       res;

    assign o_take      = i_valid && i_out_ready;
    assign o_res_valid = o_take && i_item.last_item;
    assign o_res       = res;

    always_comb begin
        if (LW'(r_max_bytes) < LW'(BUFFER_BYTES)) begin
            limit = LW'(r_max_bytes);
        end else begin
            limit = LW'(BUFFER_BYTES);
        end
    end

    assign take_byte = i_item.byte_present && (LW'(r_count) < limit);

    always_comb begin
        n_count = r_count;
        n_head  = r_head;
        n_zero  = r_zero;
        n_held  = r_held;
        n_await = r_await;
        n_fault = r_fault;
        unit    = 16'h0000;
        if (take_byte) begin
            if (i_item.data_byte == 8'h00) begin
                n_zero = 1'b1;
            end
            if (r_count < CW'(3)) begin
                case (r_count[1:0])
                    2'd0:    n_head[7:0]   = i_item.data_byte;
                    2'd1:    n_head[15:8]  = i_item.data_byte;
                    2'd2:    n_head[23:16] = i_item.data_byte;
                    default: n_head        = r_head;
                endcase
            end
            if (!r_count[0]) begin
                n_held = i_item.data_byte;
            end else begin
                if (n_head[15:0] == BOM_LE_HEAD) begin
                    unit = {i_item.data_byte, r_held};
                end else begin
                    unit = {r_held, i_item.data_byte};
                end
                if (r_await) begin
                    if ((unit & LOW_SURR_MASK) != LOW_SURR_BASE) begin
                        n_fault = 1'b1;
                    end
                    n_await = 1'b0;
                end else if ((unit & SURR_MASK) == SURR_BASE) begin
                    if (unit >= LOW_SURR_BASE) begin
                        n_fault = 1'b1;
                    end else begin
                        n_await = 1'b1;
                    end
                end
            end
            n_count = r_count + CW'(1);
        end
    end

    assign bom = (n_count >= CW'(2)) &&
                 ((n_head[15:0] == BOM_LE_HEAD) || (n_head[15:0] == BOM_BE_HEAD));
    assign utf16_ok = (n_count < CW'(4)) || (!n_count[0] && !n_fault && !n_await);

    always_comb begin
        if (n_count == '0) begin
            res = '{bin_flag: 1'b0, reason: REASON_EMPTY};
        end else if (n_zero) begin
            if (bom) begin
                if (utf16_ok) begin
                    res = '{bin_flag: 1'b0, reason: REASON_UTF16_OK};
                end else begin
                    res = '{bin_flag: 1'b1, reason: REASON_UTF16_BAD};
                end
            end else begin
                res = '{bin_flag: 1'b1, reason: REASON_NULL_BYTE};
            end
        end else if ((n_count >= CW'(3)) && (n_head == BOM_UTF8_HEAD)) begin
            res = '{bin_flag: 1'b0, reason: REASON_UTF8_BOM};
        end else begin
            res = '{bin_flag: 1'b0, reason: REASON_PLAIN};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= MAX_BYTES_RESET;
        end else if (i_cfg_we) begin
            r_max_bytes <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_take && i_item.last_item)) begin
            r_count <= '0;
            r_head  <= '0;
            r_zero  <= 1'b0;
            r_held  <= '0;
            r_await <= 1'b0;
            r_fault <= 1'b0;
        end else if (o_take) begin
            r_count <= n_count;
            r_head  <= n_head;
            r_zero  <= n_zero;
            r_held  <= n_held;
            r_await <= n_await;
            r_fault <= n_fault;
        end
    end

endmodule

[rtl/tbc_out_skid.sv]
// two-entry output buffer holding verdicts until taken
module tbc_out_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  tbc_pkg::t_result i_res,
    output logic             o_ready,
    output logic             o_valid,
    output tbc_pkg::t_result o_res,
    input  logic             i_ready
);
    import tbc_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop     = r_main_valid && i_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_res   = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_main       <= r_skid;
                r_skid_valid <= 1'b0;
            end else if (i_valid) begin
                r_main <= i_res;
            end else begin
                r_main_valid <= 1'b0;
            end
        end else if (i_valid) begin
            if (!r_main_valid) begin
                r_main       <= i_res;
                r_main_valid <= 1'b1;
            end else begin
                r_skid       <= i_res;
                r_skid_valid <= 1'b1;
            end
        end
    end

endmodule

[rtl/tbc_checker.sv]
// port-level checks for the classifier, bound to the top level
module tbc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_is_binary_verdict,
    input logic [2:0] o_reason_code
);
    import tbc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_is_binary_verdict)
                                && $stable(o_reason_code))
        else $error("verdict request dropped or changed while stalled");

    a_reason_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_reason_code <= 3'(REASON_UTF16_BAD)))
        else $error("reason code out of range");

    a_verdict_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_binary_verdict == ((o_reason_code == 3'(REASON_NULL_BYTE)) ||
                                             (o_reason_code == 3'(REASON_UTF16_BAD)))))
        else $error("verdict disagrees with reason code");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind text_binary_classifier tbc_checker u_tbc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_valid             (o_valid),
    .i_ready             (i_ready),
    .o_is_binary_verdict (o_is_binary_verdict),
    .o_reason_code       (o_reason_code)
);

[bench/text_binary_classifier_tb.sv]
// self-checking bench for the text/binary classifier: directed table, then random streams
module text_binary_classifier_tb;
    import tbc_pkg::*;

    localparam int PHASE_ITEMS  = 45;
    localparam int LIMIT_CYCLES = 400000;
    localparam int BUF_BYTES    = 64;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       present;
        logic       last;
        logic       typed;
        t_result    want;
    } t_row;

    localparam t_result FREE = '{1'b0, REASON_EMPTY};

    localparam t_row SCRIPT [0:21] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, '{1'b0, REASON_EMPTY}},
        '{8'h41, 1'b1, 1'b1, 1'b1, '{1'b0, REASON_PLAIN}},
        '{8'hEF, 1'b1, 1'b0, 1'b0, FREE},
        '{8'hBB, 1'b1, 1'b0, 1'b0, FREE},
        '{8'hBF, 1'b1, 1'b1, 1'b1, '{1'b0, REASON_UTF8_BOM}},
        '{8'h00, 1'b1, 1'b1, 1'b1, '{1'b1, REASON_NULL_BYTE}},
        '{8'hFF, 1'b1, 1'b0, 1'b0, FREE},
        '{8'hFE, 1'b1, 1'b0, 1'b0, FREE},
        '{8'h41, 1'b1, 1'b0, 1'b0, FREE},
        '{8'h00, 1'b1, 1'b1, 1'b0, FREE},
        '{8'hFF, 1'b1, 1'b0, 1'b0, FREE},
        '{8'hFE, 1'b1, 1'b0, 1'b0, FREE},
        '{8'h00, 1'b1, 1'b0, 1'b0, FREE},
        '{8'hDC, 1'b1, 1'b1, 1'b0, FREE},
        '{8'hFE, 1'b1, 1'b0, 1'b0, FREE},
        '{8'hFF, 1'b1, 1'b0, 1'b0, FREE},
        '{8'hD8, 1'b1, 1'b0, 1'b0, FREE},
        '{8'h00, 1'b1, 1'b0, 1'b0, FREE},
        '{8'h00, 1'b1, 1'b0, 1'b0, FREE},
        '{8'h41, 1'b1, 1'b1, 1'b0, FREE},
        '{8'hFF, 1'b1, 1'b0, 1'b0, FREE},
        '{8'hA5, 1'b0, 1'b1, 1'b0, FREE}
    };

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_cfg_we       = 1'b0;
    logic [MAX_BYTES_W-1:0] i_cfg_wdata    = '0;
    logic                   i_valid        = 1'b0;
    logic                   o_ready;
    logic [7:0]             i_data_byte    = '0;
    logic                   i_byte_present = 1'b0;
    logic                   i_last_item    = 1'b0;
    logic                   o_valid;
    logic                   i_ready        = 1'b1;
    logic                   o_is_binary_verdict;
    logic [2:0]             o_reason_code;

    // predictor state
    logic [10:0] limit_reg;
    logic [10:0] seen_count;
    logic [23:0] head;
    logic        zero_flag;
    logic [7:0]  even_byte;
    logic        want_low;
    logic        surr_bad;

    t_result     verdicts_due [$];
    logic [7:0]  stream_bytes [$];
    logic [10:0] limit_plan [11];
    int          faults      = 0;
    int          phase_items = 0;
    int          stall_left  = 0;
    int          calm_left   = 0;
    logic        tx_calm     = 1'b0;
    logic        wind_down   = 1'b0;

    text_binary_classifier #(
        .BUFFER_BYTES (BUF_BYTES)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_data_byte         (i_data_byte),
        .i_byte_present      (i_byte_present),
        .i_last_item         (i_last_item),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_is_binary_verdict (o_is_binary_verdict),
        .o_reason_code       (o_reason_code)
    );

    always #5 i_clk = ~i_clk;

    function automatic void restart_stream();
        seen_count = '0;
        head       = '0;
        zero_flag  = 1'b0;
        even_byte  = '0;
        want_low   = 1'b0;
        surr_bad   = 1'b0;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        logic [10:0] cap;
        logic [15:0] unit;
        cap = (limit_reg < BUF_BYTES) ? limit_reg : 11'(BUF_BYTES);
        if (seen_count >= cap) return;
        if (b == 8'h00) zero_flag = 1'b1;
        if (seen_count < 3) head = head | (24'(b) << (8 * seen_count));
        if (!seen_count[0]) begin
            even_byte = b;
        end else begin
            unit = (head[15:0] == BOM_LE_HEAD) ? {b, even_byte} : {even_byte, b};
            if (want_low) begin
                if ((unit & LOW_SURR_MASK) != LOW_SURR_BASE) surr_bad = 1'b1;
                want_low = 1'b0;
            end else if ((unit & SURR_MASK) == SURR_BASE) begin
                if (unit >= LOW_SURR_BASE) surr_bad = 1'b1;
                else want_low = 1'b1;
            end
        end
        seen_count = seen_count + 11'd1;
    endfunction

    function automatic t_result judge_stream();
        t_result r;
        r.bin_flag = 1'b0;
        r.reason   = REASON_PLAIN;
        if (seen_count == 0) begin
            r.reason = REASON_EMPTY;
        end else if (zero_flag) begin
            if (seen_count >= 2 && (head[15:0] == BOM_LE_HEAD || head[15:0] == BOM_BE_HEAD)) begin
                if (seen_count < 4 || (!seen_count[0] && !surr_bad && !want_low)) begin
                    r.reason = REASON_UTF16_OK;
                end else begin
                    r.bin_flag = 1'b1;
                    r.reason   = REASON_UTF16_BAD;
                end
            end else begin
                r.bin_flag = 1'b1;
                r.reason   = REASON_NULL_BYTE;
            end
        end else if (seen_count >= 3 && head == BOM_UTF8_HEAD) begin
            r.reason = REASON_UTF8_BOM;
        end
        return r;
    endfunction

    function automatic void take_request(input logic [7:0] b, input logic p, input logic l,
                                         input logic typed, input t_result typed_want);
        if (p) absorb_byte(b);
        if (l) begin
            verdicts_due.push_back(typed ? typed_want : judge_stream());
            restart_stream();
        end
    endfunction

    task automatic send_request(input logic [7:0] b, input logic p, input logic l,
                                input logic typed, input t_result typed_want);
        i_valid        <= 1'b1;
        i_data_byte    <= b;
        i_byte_present <= p;
        i_last_item    <= l;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        take_request(b, p, l, typed, typed_want);
        if (!tx_calm && !wind_down && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic program_limit(input logic [10:0] v);
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        limit_reg = v;
    endtask

    function automatic void build_stream(input int unsigned longest);
        int unsigned flavour;
        int unsigned units;
        logic        big_end;
        logic [15:0] units_q [$];
        flavour = $urandom_range(0, 7);
        units   = ($urandom_range(0, 19) == 0) ? $urandom_range(11, longest)
                                               : $urandom_range(0, 10);
        stream_bytes.delete();
        case (flavour)
            0, 1, 2, 3: begin
                // utf-16 text behind a byte order mark
                big_end = flavour[0];
                units_q.push_back(16'hFEFF);
                repeat (units) begin
                    case ($urandom_range(0, 11))
                        0, 1, 2, 3, 4: units_q.push_back({8'h00, 8'($urandom_range(32, 126))});
                        5, 6, 7: begin
                            units_q.push_back(SURR_BASE | 16'($urandom_range(0, 1023)));
                            units_q.push_back(LOW_SURR_BASE | 16'($urandom_range(0, 1023)));
                        end
                        8: units_q.push_back(SURR_BASE | 16'($urandom_range(0, 1023)));
                        9: units_q.push_back(LOW_SURR_BASE | 16'($urandom_range(0, 1023)));
                        default: units_q.push_back(16'($urandom));
                    endcase
                end
                foreach (units_q[k]) begin
                    if (big_end) begin
                        stream_bytes.push_back(units_q[k][15:8]);
                        stream_bytes.push_back(units_q[k][7:0]);
                    end else begin
                        stream_bytes.push_back(units_q[k][7:0]);
                        stream_bytes.push_back(units_q[k][15:8]);
                    end
                end
                if ($urandom_range(0, 7) == 0) begin
                    if ($urandom_range(0, 1) == 0) void'(stream_bytes.pop_back());
                    else stream_bytes.push_back(8'($urandom));
                end
            end
            4, 5: begin
                // utf-8 mark, sometimes cut short
                stream_bytes.push_back(BOM_UTF8_HEAD[7:0]);
                if ($urandom_range(0, 5) != 0) stream_bytes.push_back(BOM_UTF8_HEAD[15:8]);
                if ($urandom_range(0, 5) != 0) stream_bytes.push_back(BOM_UTF8_HEAD[23:16]);
                repeat (units) begin
                    if ($urandom_range(0, 15) == 0) stream_bytes.push_back(8'h00);
                    else stream_bytes.push_back(8'($urandom_range(32, 126)));
                end
            end
            6: begin
                repeat (2 * units) begin
                    if ($urandom_range(0, 7) == 0) stream_bytes.push_back(8'h00);
                    else stream_bytes.push_back(8'($urandom));
                end
            end
            default: begin
                // utf-16 marks or near-miss heads followed by noise
                case ($urandom_range(0, 3))
                    0: begin stream_bytes.push_back(8'hFF); stream_bytes.push_back(8'hFE); end
                    1: begin stream_bytes.push_back(8'hFE); stream_bytes.push_back(8'hFF); end
                    2: begin stream_bytes.push_back(8'hEF); stream_bytes.push_back(8'hBB); end
                    default: begin stream_bytes.push_back(8'hFF); stream_bytes.push_back(8'hFF); end
                endcase
                repeat ($urandom_range(0, 2 * units + 1)) begin
                    if ($urandom_range(0, 3) == 0) stream_bytes.push_back(8'h00);
                    else stream_bytes.push_back(8'($urandom));
                end
            end
        endcase
    endfunction

    task automatic send_stream();
        logic split_end;
        split_end = (stream_bytes.size() == 0) || ($urandom_range(0, 3) == 0);
        tx_calm   = ($urandom_range(0, 3) == 0);
        foreach (stream_bytes[k]) begin
            if ($urandom_range(0, 9) == 0) send_request(8'($urandom), 1'b0, 1'b0, 1'b0, FREE);
            send_request(stream_bytes[k], 1'b1, !split_end && k == stream_bytes.size() - 1,
                         1'b0, FREE);
            phase_items++;
        end
        if (split_end) begin
            send_request(8'($urandom), 1'b0, 1'b1, 1'b0, FREE);
            phase_items++;
        end
    endtask

    // receiving side: random stall bursts, calm stretches, none while winding down
    always @(posedge i_clk) begin
        if (wind_down) begin
            i_ready <= 1'b1;
            stall_left = 0;
        end else if (stall_left != 0) begin
            stall_left--;
            if (stall_left == 0) i_ready <= 1'b1;
        end else if (calm_left != 0) begin
            calm_left--;
        end else if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(20, 80);
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 12);
            i_ready <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected verdict: binary %0b reason %0d",
                         $time, o_is_binary_verdict, o_reason_code);
                faults++;
            end else begin
                want = verdicts_due.pop_front();
                if (o_is_binary_verdict !== want.bin_flag) begin
                    $display("%0t: binary flag expected %0b actual %0b",
                             $time, want.bin_flag, o_is_binary_verdict);
                    faults++;
                end
                if (o_reason_code !== want.reason) begin
                    $display("%0t: reason expected %0d actual %0d",
                             $time, want.reason, o_reason_code);
                    faults++;
                end
            end
        end
    end

    initial begin
        limit_plan = '{11'd0, 11'd1, 11'd2, 11'd3, 11'd4, 11'd5, 11'd2047, 11'd1025,
                       11'd0, 11'd0, 11'd1024};
        limit_plan[8] = 11'($urandom_range(6, 40));
        limit_plan[9] = 11'($urandom_range(0, 2047));
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        limit_reg = MAX_BYTES_RESET;
        restart_stream();

        foreach (SCRIPT[r])
            send_request(SCRIPT[r].data_byte, SCRIPT[r].present, SCRIPT[r].last,
                         SCRIPT[r].typed, SCRIPT[r].want);
        i_valid <= 1'b0;

        foreach (limit_plan[p]) begin
            program_limit(limit_plan[p]);
            wind_down = (p == 10);
            if (limit_plan[p] == 11'd2047) begin
                // one stream longer than the buffer
                stream_bytes.delete();
                repeat (BUF_BYTES + 6) stream_bytes.push_back(8'($urandom));
                send_stream();
            end
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                build_stream(40);
                send_stream();
            end
            i_valid <= 1'b0;
        end

        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (faults == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * 10);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[text_binary_classifier.f]
rtl/tbc_pkg.sv
rtl/tbc_in_reg.sv
rtl/tbc_core.sv
rtl/tbc_out_skid.sv
rtl/text_binary_classifier.sv
rtl/tbc_checker.sv
bench/text_binary_classifier_tb.sv
